### design/layer_priority_mixer_assert.svh
// ---------------------------------------------------------------------------
// Layer priority mixer assertion macros
// Shared property forms for the mixer's concurrent checks, clocked on clk
// and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LAYER_PRIORITY_MIXER_ASSERT_SVH
`define LAYER_PRIORITY_MIXER_ASSERT_SVH

// Same-cycle implication.
`define LPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lpm_pkg.sv
// ---------------------------------------------------------------------------
// Layer priority mixer package
// Shared widths, codes, register indexes and the queue entry type.
// ---------------------------------------------------------------------------
package lpm_pkg;

  localparam int IDX_W      = 6;
  localparam int COLOR_W    = 9;
  localparam int MODE_W     = 2;
  localparam int CRAM_DEPTH = 64;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam int LPM_QUEUE_DEPTH = 4;

  typedef enum logic {
    CMD_MIX   = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_DISPLAY_ENABLE = 2'd0,
    REG_SH_ENABLE      = 2'd1,
    REG_BACKDROP_INDEX = 2'd2
  } reg_idx_t;

  localparam logic [MODE_W-1:0] SHADE_SHADOW    = 2'd0;
  localparam logic [MODE_W-1:0] SHADE_NORMAL    = 2'd1;
  localparam logic [MODE_W-1:0] SHADE_HIGHLIGHT = 2'd2;

  // Sprite indices with special meaning.
  localparam logic [IDX_W-1:0] SPR_FORCE_NORMAL_0 = 6'h0e;
  localparam logic [IDX_W-1:0] SPR_FORCE_NORMAL_1 = 6'h1e;
  localparam logic [IDX_W-1:0] SPR_FORCE_NORMAL_2 = 6'h2e;
  localparam logic [IDX_W-1:0] SPR_HIGHLIGHT      = 6'h3e;
  localparam logic [IDX_W-1:0] SPR_SHADOW         = 6'h3f;

  typedef struct packed {
    logic             display_enable;
    logic             sh_enable;
    logic [IDX_W-1:0] backdrop_index;
  } cfg_t;

  // One classified beat: a color RAM write or a resolved pixel lookup.
  typedef struct packed {
    cmd_t               cmd;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] data;
    logic [MODE_W-1:0]  mode;
    logic               blank;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### design/lpm_front.sv
// ---------------------------------------------------------------------------
// Layer priority mixer front end
// Unpacks an input beat and resolves layer priority, special sprite indices
// and the shade mode into one queue entry.
// ---------------------------------------------------------------------------
module lpm_front (
  input  logic [lpm_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  lpm_pkg::cfg_t                 cfg,
  output lpm_pkg::q_entry_t             entry
);
  import lpm_pkg::*;

  logic [IDX_W-1:0]   ac;
  logic               ap;
  logic [IDX_W-1:0]   bc;
  logic               bp;
  logic [IDX_W-1:0]   sc;
  logic               sp;
  logic               active;
  logic [IDX_W-1:0]   ram_index;
  logic [COLOR_W-1:0] ram_data;
  logic               a_up;
  logic               b_up;
  logic               s_up;
  logic [IDX_W-1:0]   bg;
  logic [IDX_W-1:0]   fg;
  logic [MODE_W-1:0]  mode;
  logic               base;

  assign ac        = in_tdata[5:0];
  assign ap        = in_tdata[6];
  assign bc        = in_tdata[12:7];
  assign bp        = in_tdata[13];
  assign sc        = in_tdata[19:14];
  assign sp        = in_tdata[20];
  assign active    = in_tdata[21];
  assign ram_index = in_tdata[27:22];
  assign ram_data  = in_tdata[36:28];

  assign a_up = ap && (ac != '0);
  assign b_up = bp && (bc != '0);
  assign s_up = sp && (sc != '0);
  assign base = ap | bp;

  always_comb begin
    if (a_up || ((ac != '0) && !b_up)) begin
      bg = ac;
    end else if (bc != '0) begin
      bg = bc;
    end else begin
      bg = cfg.backdrop_index;
    end

    mode = {1'b0, base};
    fg   = bg;
    if (s_up || ((sc != '0) && !b_up && !a_up)) begin
      fg = sc;
      case (sc) inside
        SPR_FORCE_NORMAL_0, SPR_FORCE_NORMAL_1, SPR_FORCE_NORMAL_2: begin
          mode = SHADE_NORMAL;
        end
        SPR_HIGHLIGHT: begin
          mode = {1'b0, base} + 2'd1;
          fg   = bg;
        end
        SPR_SHADOW: begin
          mode = SHADE_SHADOW;
          fg   = bg;
        end
        default: begin
          mode = {1'b0, base | sp};
        end
      endcase
    end

    if (!cfg.sh_enable) begin
      mode = SHADE_NORMAL;
    end

    entry.cmd   = cmd_t'(in_tuser);
    entry.blank = !cfg.display_enable || !active;
    if (entry.cmd == CMD_WRITE) begin
      entry.idx  = ram_index;
      entry.data = ram_data;
      entry.mode = mode;
    end else begin
      entry.idx  = fg;
      entry.data = ram_data;
      entry.mode = entry.blank ? SHADE_SHADOW : mode;
    end
  end

endmodule

### design/lpm_queue.sv
// ---------------------------------------------------------------------------
// Layer priority mixer queue
// Short FIFO of classified entries between the front end and the back end.
// ---------------------------------------------------------------------------
module lpm_queue #(
  parameter int Depth = lpm_pkg::LPM_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpm_pkg::q_entry_t   push_data,
  input  logic                pop,
  output lpm_pkg::q_entry_t   pop_data,
  output lpm_pkg::q_status_t  status
);
  import lpm_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  q_entry_t          q_mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count_r == CntW'(Depth));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/lpm_back.sv
// ---------------------------------------------------------------------------
// Layer priority mixer back end
// Executes queue entries against the color RAM and holds the result beat.
// ---------------------------------------------------------------------------
module lpm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lpm_pkg::q_entry_t               entry,
  input  logic                            entry_valid,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lpm_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import lpm_pkg::*;

  logic [COLOR_W-1:0]    cram [CRAM_DEPTH];
  logic [CRAM_DEPTH-1:0] cram_vld_r;
  logic [COLOR_W-1:0]    rd_data_r;
  logic                  rd_vld_r;
  logic                  s1_valid_r, s1_valid_nxt;
  logic [MODE_W-1:0]     s1_mode_r;
  logic                  s1_blank_r;
  logic                  is_write;
  logic                  pop_wr;
  logic                  pop_rd;
  logic [COLOR_W-1:0]    color;

  assign is_write = (entry.cmd == CMD_WRITE);
  // A write never occupies the result stage, so it drains even under a stall.
  assign pop_wr   = entry_valid && is_write;
  assign pop_rd   = entry_valid && !is_write && (!s1_valid_r || out_tready);
  assign pop      = pop_wr || pop_rd;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (pop_rd) begin
      s1_valid_nxt = 1'b1;
    end else if (out_tready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cram_vld_r <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (pop_wr) begin
        cram_vld_r[entry.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_wr) begin
      cram[entry.idx] <= entry.data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_rd) begin
      rd_data_r  <= cram[entry.idx];
      rd_vld_r   <= cram_vld_r[entry.idx];
      s1_mode_r  <= entry.mode;
      s1_blank_r <= entry.blank;
    end
  end

  // Entries never written since reset read as zero.
  assign color      = (s1_blank_r || !rd_vld_r) ? '0 : rd_data_r;
  assign out_tvalid = s1_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - COLOR_W - MODE_W){1'b0}}, color, s1_mode_r};

endmodule

### design/layer_priority_mixer.sv
// ---------------------------------------------------------------------------
// Layer priority mixer
// Per-dot layer priority mixer with shadow/highlight and color RAM lookup.
//
// Input channel in_*: one beat per dot. in_tuser selects a pixel mix (0) or a
// color RAM word write (1). A mix beat gives one result beat on out_*; a
// write beat gives none. Results leave in the order their beats came in.
// A mix beat enters the entry queue when accepted, and the color RAM read
// then registers its result, which drives out_tvalid. Throughput is one beat
// per cycle on both sides while out_tready stays high; the back end retires
// one queue entry, a color RAM write or a read, per cycle and sets that rate.
// When out_tready is low the result beat holds, the four-entry queue fills
// and in_tready drops once it is full; write beats still drain behind a held
// result. Reset clears the queue, the result stage, the registers and the
// per-entry valid bits of the color RAM, so unwritten entries read as zero
// and no clearing pass is needed. Registers sit on the APB port cfg_*:
// display_enable at 0x0, shadow_highlight_enable at 0x4, backdrop_index at
// 0x8; write them only while the block is idle.
// ---------------------------------------------------------------------------
module layer_priority_mixer #(
  parameter int QueueDepth = lpm_pkg::LPM_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [5:0] plane_a_color, [6] plane_a_priority, [12:7] plane_b_color,
  // [13] plane_b_priority, [19:14] sprite_color, [20] sprite_priority,
  // [21] active_line, [27:22] ram_index, [36:28] ram_data, [39:37] zero
  input  logic [lpm_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] cmd
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] shade_mode, [10:2] rgb_color, [15:11] zero
  output logic [lpm_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [lpm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [lpm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [lpm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import lpm_pkg::*;

  `include "layer_priority_mixer_assert.svh"

  logic              de_r;
  logic              she_r;
  logic [IDX_W-1:0]  bd_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  cfg_t              cfg;
  q_entry_t          front_entry;
  q_entry_t          back_entry;
  q_status_t         q_status;
  logic              q_pop;
  logic              in_fire;
  logic              q_idle;
  logic [MODE_W-1:0] out_mode;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      de_r  <= 1'b0;
      she_r <= 1'b0;
      bd_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DISPLAY_ENABLE: de_r  <= cfg_pwdata[0];
        REG_SH_ENABLE:      she_r <= cfg_pwdata[0];
        REG_BACKDROP_INDEX: bd_r  <= cfg_pwdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DISPLAY_ENABLE: cfg_prdata = {{(CFG_DATA_W - 1){1'b0}}, de_r};
      REG_SH_ENABLE:      cfg_prdata = {{(CFG_DATA_W - 1){1'b0}}, she_r};
      REG_BACKDROP_INDEX: cfg_prdata = {{(CFG_DATA_W - IDX_W){1'b0}}, bd_r};
      default:            cfg_prdata = '0;
    endcase
  end

  assign cfg.display_enable = de_r;
  assign cfg.sh_enable      = she_r;
  assign cfg.backdrop_index = bd_r;

  assign in_tready = !q_status.full;
  assign in_fire   = in_tvalid && in_tready;
  assign q_idle    = q_status.empty && !in_fire;
  assign out_mode  = out_tdata[1:0];

  lpm_front u_front (
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg      (cfg),
    .entry    (front_entry)
  );

  lpm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (front_entry),
    .pop       (q_pop),
    .pop_data  (back_entry),
    .status    (q_status)
  );

  lpm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry       (back_entry),
    .entry_valid (!q_status.empty),
    .pop         (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  `LPM_ASSERT_NOW(a_q_full_empty, q_status.full, !q_status.empty, "queue full and empty at once")
  `LPM_ASSERT_NOW(a_shade_range, out_tvalid, out_mode != 2'b11, "shade mode out of range")
  `LPM_ASSERT_NOW(a_sh_off, out_tvalid && !she_r, out_mode != SHADE_HIGHLIGHT, "bad highlight")
  `LPM_ASSERT_NEXT(a_no_pop_empty, q_idle, !out_tvalid || $stable(out_tdata), "result moved")

endmodule

### tb/sv/layer_priority_mixer_tb.sv
// ---------------------------------------------------------------------------
// Layer priority mixer testbench
// Streams pixel mix beats and color RAM write beats into the mixer, predicts
// each pixel's shade mode and color in the bench, and compares every result
// beat in order. Both stream sides idle at random. Directed cases cover
// priority resolution, the backdrop fallback and the special sprite codes.
// Random phases then run under several register settings.
// ---------------------------------------------------------------------------
module layer_priority_mixer_tb;
  import lpm_pkg::*;

  // Field layout of in_tdata, highest bits first.
  typedef struct packed {
    logic [2:0]         pad;
    logic [COLOR_W-1:0] ram_data;
    logic [IDX_W-1:0]   ram_index;
    logic               active_line;
    logic               s_prio;
    logic [IDX_W-1:0]   s_color;
    logic               b_prio;
    logic [IDX_W-1:0]   b_color;
    logic               a_prio;
    logic [IDX_W-1:0]   a_color;
  } dot_t;

  typedef struct packed {
    logic [COLOR_W-1:0] rgb;
    logic [MODE_W-1:0]  shade;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // fields as in dot_t, a_color lowest
  logic                  in_tuser;   // [0] cmd
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [1:0] shade_mode, [10:2] rgb_color
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Bench copy of the block's state.
  cfg_t               mixer_cfg;
  logic [COLOR_W-1:0] palette [CRAM_DEPTH];
  pixel_t             pending_pixels [$];

  int unsigned failures = 0;
  bit          idle_on  = 1'b1;

  layer_priority_mixer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("layer_priority_mixer_tb NOT OK");
    $finish;
  end

  function automatic int unsigned draw_wait();
    return idle_on ? $urandom_range(0, 4) : 0;
  endfunction

  function automatic pixel_t mix_pixel(dot_t d);
    logic               a_up, b_up, s_up;
    logic [IDX_W-1:0]   bg, fg;
    logic [MODE_W-1:0]  mode;
    pixel_t             p;
    p = '0;
    if (!mixer_cfg.display_enable || !d.active_line) return p;
    a_up = d.a_prio && (d.a_color != '0);
    b_up = d.b_prio && (d.b_color != '0);
    s_up = d.s_prio && (d.s_color != '0);
    if (a_up || (d.a_color != '0 && !b_up)) bg = d.a_color;
    else if (d.b_color != '0) bg = d.b_color;
    else bg = mixer_cfg.backdrop_index;
    // The plane priority bits count even on transparent pixels.
    mode = {1'b0, d.a_prio | d.b_prio};
    fg = bg;
    if (s_up || (d.s_color != '0 && !a_up && !b_up)) begin
      fg = d.s_color;
      case (d.s_color)
        SPR_FORCE_NORMAL_0, SPR_FORCE_NORMAL_1, SPR_FORCE_NORMAL_2: begin
          mode = SHADE_NORMAL;
        end
        SPR_HIGHLIGHT: begin
          mode = mode + 2'd1;
          fg = bg;
        end
        SPR_SHADOW: begin
          mode = SHADE_SHADOW;
          fg = bg;
        end
        default: begin
          mode = mode | {1'b0, d.s_prio};
        end
      endcase
    end
    if (!mixer_cfg.sh_enable) mode = SHADE_NORMAL;
    p.shade = mode;
    p.rgb   = palette[fg];
    return p;
  endfunction

  function automatic dot_t mix_dot(logic [IDX_W-1:0] ac, logic ap, logic [IDX_W-1:0] bc,
                                   logic bp, logic [IDX_W-1:0] sc, logic sp, logic act);
    dot_t d;
    d = '0;
    d.a_color = ac; d.a_prio = ap;
    d.b_color = bc; d.b_prio = bp;
    d.s_color = sc; d.s_prio = sp;
    d.active_line = act;
    // RAM fields are don't-care on a mix beat; keep them busy.
    d.ram_index = IDX_W'($urandom_range(0, 63));
    d.ram_data  = COLOR_W'($urandom_range(0, 511));
    return d;
  endfunction

  function automatic dot_t ram_dot(logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
    dot_t d;
    d = '0;
    d[21:0] = 22'($urandom);
    d.ram_index = idx;
    d.ram_data  = data;
    return d;
  endfunction

  function automatic logic [IDX_W-1:0] pick_color();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r == 3) return 6'h3f;
    return IDX_W'($urandom_range(1, 63));
  endfunction

  function automatic logic [IDX_W-1:0] pick_sprite();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    case (r)
      2: return SPR_FORCE_NORMAL_0;
      3: return SPR_FORCE_NORMAL_1;
      4: return SPR_FORCE_NORMAL_2;
      5: return SPR_HIGHLIGHT;
      6: return SPR_SHADOW;
      default: return IDX_W'($urandom_range(1, 63));
    endcase
  endfunction

  task automatic send_dot(cmd_t cmd, dot_t d);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= cmd;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (cmd == CMD_WRITE) palette[d.ram_index] = d.ram_data;
    else pending_pixels.push_back(mix_pixel(d));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Write beats give no result, so allow the queue and read stage to empty.
  task automatic wait_idle();
    drain_results();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [CFG_DATA_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (r)
      REG_DISPLAY_ENABLE: mixer_cfg.display_enable = v[0];
      REG_SH_ENABLE:      mixer_cfg.sh_enable      = v[0];
      REG_BACKDROP_INDEX: mixer_cfg.backdrop_index = v[IDX_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic disp, logic sh, logic [IDX_W-1:0] backdrop);
    wait_idle();
    write_reg(REG_DISPLAY_ENABLE, {31'd0, disp});
    write_reg(REG_SH_ENABLE, {31'd0, sh});
    write_reg(REG_BACKDROP_INDEX, {26'd0, backdrop});
  endtask

  task automatic flag(string what, int unsigned want, int unsigned got);
    failures++;
    if (failures <= 10)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  // Result side: random stalls, then compare each beat with the oldest pixel.
  initial begin : result_check
    pixel_t      got;
    pixel_t      want;
    int unsigned stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got.shade = out_tdata[1:0];
      got.rgb   = out_tdata[10:2];
      if (pending_pixels.size() == 0) begin
        flag("unexpected result beat", 0, 32'(out_tdata));
      end else begin
        want = pending_pixels.pop_front();
        if (got.shade !== want.shade) flag("shade_mode", 32'(want.shade), 32'(got.shade));
        if (got.rgb !== want.rgb) flag("rgb_color", 32'(want.rgb), 32'(got.rgb));
      end
    end
  end

  // Registers at reset: display off blanks every pixel.
  task automatic test_reset_blanking();
    send_dot(CMD_MIX, mix_dot(6'h3f, 1'b1, 6'h3f, 1'b1, 6'h3f, 1'b1, 1'b1));
    send_dot(CMD_WRITE, ram_dot(6'h3f, 9'h1ff));
    send_dot(CMD_MIX, mix_dot(6'h3f, 1'b0, 6'h00, 1'b0, 6'h00, 1'b0, 1'b1));
  endtask

  task automatic test_priority_rules();
    send_dot(CMD_WRITE, ram_dot(6'h05, 9'h0a5));
    send_dot(CMD_WRITE, ram_dot(6'h11, 9'h111));
    send_dot(CMD_WRITE, ram_dot(6'h22, 9'h122));
    send_dot(CMD_WRITE, ram_dot(6'h33, 9'h133));
    send_dot(CMD_WRITE, ram_dot(SPR_FORCE_NORMAL_0, 9'h00e));
    send_dot(CMD_WRITE, ram_dot(SPR_FORCE_NORMAL_2, 9'h12e));
    send_dot(CMD_WRITE, ram_dot(6'h00, 9'h000));
    set_config(1'b1, 1'b1, 6'h05);
    // Backdrop, with and without a priority bit on a transparent plane.
    send_dot(CMD_MIX, mix_dot(6'h00, 1'b0, 6'h00, 1'b0, 6'h00, 1'b0, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h00, 1'b1, 6'h00, 1'b0, 6'h00, 1'b0, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h11, 1'b0, 6'h22, 1'b0, 6'h00, 1'b0, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h11, 1'b0, 6'h22, 1'b1, 6'h00, 1'b0, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h11, 1'b1, 6'h22, 1'b1, 6'h00, 1'b0, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h11, 1'b1, 6'h22, 1'b0, 6'h33, 1'b0, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h11, 1'b1, 6'h22, 1'b0, 6'h33, 1'b1, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h11, 1'b0, 6'h22, 1'b0, 6'h33, 1'b0, 1'b1));
    // Special sprite codes.
    send_dot(CMD_MIX, mix_dot(6'h11, 1'b0, 6'h00, 1'b0, SPR_FORCE_NORMAL_0, 1'b0, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h00, 1'b0, 6'h22, 1'b0, SPR_FORCE_NORMAL_1, 1'b0, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h00, 1'b0, 6'h22, 1'b1, SPR_FORCE_NORMAL_2, 1'b1, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h11, 1'b0, 6'h00, 1'b0, SPR_HIGHLIGHT, 1'b0, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h00, 1'b0, 6'h22, 1'b1, SPR_HIGHLIGHT, 1'b1, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h11, 1'b1, 6'h00, 1'b0, SPR_HIGHLIGHT, 1'b0, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h00, 1'b0, 6'h22, 1'b1, SPR_SHADOW, 1'b1, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h3f, 1'b1, 6'h3f, 1'b1, SPR_SHADOW, 1'b1, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h11, 1'b1, 6'h22, 1'b1, 6'h33, 1'b1, 1'b0));
    // Shadow/highlight off forces normal; the largest backdrop index.
    set_config(1'b1, 1'b0, 6'h3f);
    send_dot(CMD_MIX, mix_dot(6'h00, 1'b0, 6'h22, 1'b1, SPR_SHADOW, 1'b1, 1'b1));
    send_dot(CMD_MIX, mix_dot(6'h00, 1'b1, 6'h00, 1'b1, 6'h00, 1'b1, 1'b1));
  endtask

  task automatic test_random_phases();
    dot_t d;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(1'b1, 1'b1, 6'h00);
        1: set_config(1'b1, 1'b1, 6'h3f);
        2: set_config(1'b1, 1'b0, IDX_W'($urandom_range(0, 63)));
        3: set_config(1'b0, 1'b1, IDX_W'($urandom_range(0, 63)));
        4: set_config(1'b1, 1'b1, IDX_W'($urandom_range(0, 63)));
        default: set_config(1'b1, 1'b1, IDX_W'($urandom_range(0, 63)));
      endcase
      if (ph == 0) begin
        idle_on = 1'b0;
        for (int i = 0; i < CRAM_DEPTH; i++)
          send_dot(CMD_WRITE, ram_dot(IDX_W'(i), COLOR_W'($urandom_range(0, 511))));
      end
      for (int n = 0; n < 180; n++) begin
        if (n % 30 == 0) idle_on = ($urandom_range(0, 3) != 0);
        if (n == 90) drain_results();
        if ($urandom_range(0, 99) < 15) begin
          send_dot(CMD_WRITE, ram_dot(IDX_W'($urandom_range(0, 63)),
                                      COLOR_W'($urandom_range(0, 511))));
        end else begin
          d = mix_dot(pick_color(), 1'($urandom_range(0, 1)), pick_color(),
                      1'($urandom_range(0, 1)), pick_sprite(), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 9) != 0);
          send_dot(CMD_MIX, d);
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= CMD_MIX;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    mixer_cfg = '0;
    foreach (palette[i]) palette[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_blanking();
    test_priority_rules();
    test_random_phases();
    wait_idle();

    if (failures == 0) begin
      $display("layer_priority_mixer_tb OK");
    end else begin
      $display("layer_priority_mixer_tb NOT OK");
    end
    $finish;
  end

endmodule
